[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and opcodes of the fixed-point complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int FIELD_W = 32;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [FIELD_W-1:0] a_re;
		logic signed [FIELD_W-1:0] a_im;
		logic signed [FIELD_W-1:0] b_re;
		logic signed [FIELD_W-1:0] b_im;
	} cau_req_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] res_re;
		logic signed [FIELD_W-1:0] res_im;
		logic                      div_zero;
		logic                      saturated;
	} cau_res_t;

endpackage

[rtl/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider: one quotient bit per stage, with an
// overflow check up front so only W quotient bits need to be resolved.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int W     = 32,
	parameter int F     = 16,
	parameter int TAG_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [2*W+F-1:0]   in_mag,
	input  logic [2*W-1:0]     in_den,
	input  logic [TAG_W-1:0]   in_tag,
	output logic               out_vld,
	output logic [W-1:0]       out_quo,
	output logic               out_ovf,
	output logic [TAG_W-1:0]   out_tag
);

	localparam int HW = W + F;
	localparam int CW = (HW > 2*W) ? HW : 2*W;

	logic             vld_s [0:W];
	logic [2*W-1:0]   rem_s [0:W];
	logic [W-1:0]     quo_s [0:W];
	logic [W-1:0]     low_s [0:W];
	logic [2*W-1:0]   den_s [0:W];
	logic             ovf_s [0:W];
	logic [TAG_W-1:0] tag_s [0:W];

	logic [HW-1:0] hi_part;
	logic          hi_ovf;

	// quotient of the upper part must be zero, else result exceeds W bits
	assign hi_part = in_mag[2*W+F-1:W];
	assign hi_ovf  = CW'(hi_part) >= CW'(in_den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= (2*W)'(hi_part);
		quo_s[0] <= '0;
		low_s[0] <= in_mag[W-1:0];
		den_s[0] <= in_den;
		ovf_s[0] <= hi_ovf;
		tag_s[0] <= in_tag;
	end

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [2*W:0]   trial;
		logic           take;
		logic [2*W:0]   diff;
		logic [2*W-1:0] rem_nxt;

		assign trial   = {rem_s[k], low_s[k][W-1]};
		assign take    = trial >= {1'b0, den_s[k]};
		assign diff    = trial - {1'b0, den_s[k]};
		assign rem_nxt = take ? diff[2*W-1:0] : trial[2*W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_nxt;
			quo_s[k+1] <= {quo_s[k][W-2:0], take};
			low_s[k+1] <= {low_s[k][W-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			ovf_s[k+1] <= ovf_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_vld = vld_s[W];
	assign out_quo = quo_s[W];
	assign out_ovf = ovf_s[W];
	assign out_tag = tag_s[W];

endmodule

[rtl/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// Fixed-point complex add, subtract, multiply and divide, fully pipelined.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy is tied low as
// the pipeline never stalls. Every request returns exactly one result, with
// done high for one cycle; all opcodes take the same path through the
// divider, which resolves one quotient bit per stage, so results leave in
// request order; add, subtract and multiply ride alongside the divide. The
// receiver must take each result in the cycle it is shown.
// Stages: operand capture, six signed products, sums and divisor, magnitude
// and shift, overflow check, DATA_WIDTH quotient stages, clamp and output.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cau_req_t req,
	output logic     done,
	output cau_res_t res
);

	localparam int W       = DATA_WIDTH;
	localparam int F       = FRAC_BITS;
	localparam int SW      = 2*W + 1;
	localparam int AW      = 2*W + F;
	localparam int EW      = (W > FIELD_W) ? W : FIELD_W;
	localparam int TAG_W   = 4 + 2*SW;
	localparam int LATENCY = W + 6;

	localparam logic signed [SW-1:0] MAXV = signed'({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] MINV = signed'({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});
	localparam logic [W-1:0]         HALF = {1'b1, {(W-1){1'b0}}};

	// low W bits of a field, read as signed (zero-extended if W exceeds the field)
	function automatic logic signed [W-1:0] opnd(input logic [FIELD_W-1:0] f);
		logic [EW-1:0] zx;
		zx = EW'(f);
		return signed'(zx[W-1:0]);
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [W-1:0] v);
		logic [EW-1:0] zx;
		zx = EW'(v);
		return zx[FIELD_W-1:0];
	endfunction

	assign busy = 1'b0;

	// ---- stage 1: operand capture
	logic                vld_s1;
	logic [1:0]          op_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= req.op;
		ar_s1 <= opnd(req.a_re);
		ai_s1 <= opnd(req.a_im);
		br_s1 <= opnd(req.b_re);
		bi_s1 <= opnd(req.b_im);
	end

	// ---- stage 2: products, add/sub
	logic                  vld_s2;
	logic [1:0]            op_s2;
	logic signed [2*W-1:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, sq_r_s2, sq_i_s2;
	logic signed [W:0]     as_re_s2, as_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		p_rr_s2 <= ar_s1 * br_s1;
		p_ii_s2 <= ai_s1 * bi_s1;
		p_ir_s2 <= ai_s1 * br_s1;
		p_ri_s2 <= ar_s1 * bi_s1;
		sq_r_s2 <= br_s1 * br_s1;
		sq_i_s2 <= bi_s1 * bi_s1;
		if (op_s1 == OP_SUB) begin
			as_re_s2 <= ar_s1 - br_s1;
			as_im_s2 <= ai_s1 - bi_s1;
		end else begin
			as_re_s2 <= ar_s1 + br_s1;
			as_im_s2 <= ai_s1 + bi_s1;
		end
	end

	// ---- stage 3: sums; numerators for divide, final values otherwise
	logic                 vld_s3;
	logic [1:0]           op_s3;
	logic signed [SW-1:0] val_re_s3, val_im_s3;
	logic [2*W-1:0]       den_s3;
	logic signed [SW-1:0] val_re_d, val_im_d;

	always_comb begin
		case (op_s2)
			OP_MUL: begin
				val_re_d = (SW'(p_rr_s2) - SW'(p_ii_s2)) >>> F;
				val_im_d = (SW'(p_ir_s2) + SW'(p_ri_s2)) >>> F;
			end
			OP_DIV: begin
				val_re_d = SW'(p_rr_s2) + SW'(p_ii_s2);
				val_im_d = SW'(p_ir_s2) - SW'(p_ri_s2);
			end
			default: begin
				val_re_d = SW'(as_re_s2);
				val_im_d = SW'(as_im_s2);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		val_re_s3 <= val_re_d;
		val_im_s3 <= val_im_d;
		den_s3    <= $unsigned(sq_r_s2) + $unsigned(sq_i_s2);
	end

	// ---- stage 4: magnitudes, scaled dividends
	logic                 vld_s4;
	logic [1:0]           op_s4;
	logic                 dz_s4, neg_re_s4, neg_im_s4;
	logic signed [SW-1:0] val_re_s4, val_im_s4;
	logic [AW-1:0]        mag_re_s4, mag_im_s4;
	logic [2*W-1:0]       den_s4;
	logic [SW-1:0]        abs_re, abs_im;

	assign abs_re = val_re_s3[SW-1] ? -val_re_s3 : val_re_s3;
	assign abs_im = val_im_s3[SW-1] ? -val_im_s3 : val_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s4     <= op_s3;
		dz_s4     <= (op_s3 == OP_DIV) && (den_s3 == '0);
		neg_re_s4 <= val_re_s3[SW-1];
		neg_im_s4 <= val_im_s3[SW-1];
		val_re_s4 <= val_re_s3;
		val_im_s4 <= val_im_s3;
		mag_re_s4 <= AW'(abs_re[2*W-1:0]) << F;
		mag_im_s4 <= AW'(abs_im[2*W-1:0]) << F;
		den_s4    <= den_s3;
	end

	// ---- divider pipes; the real one carries the side data of every request
	logic             dv_vld, dv_ovf_re, dv_ovf_im, dv_unused_vld;
	logic [W-1:0]     dv_q_re, dv_q_im;
	logic [TAG_W-1:0] tag_in, tag_out;
	logic             neg_im_out;

	assign tag_in = {op_s4, dz_s4, neg_re_s4, val_re_s4, val_im_s4};

	cau_div #(.W(W), .F(F), .TAG_W(TAG_W)) u_div_re (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.in_mag  (mag_re_s4),
		.in_den  (den_s4),
		.in_tag  (tag_in),
		.out_vld (dv_vld),
		.out_quo (dv_q_re),
		.out_ovf (dv_ovf_re),
		.out_tag (tag_out)
	);

	cau_div #(.W(W), .F(F), .TAG_W(1)) u_div_im (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.in_mag  (mag_im_s4),
		.in_den  (den_s4),
		.in_tag  (neg_im_s4),
		.out_vld (dv_unused_vld),
		.out_quo (dv_q_im),
		.out_ovf (dv_ovf_im),
		.out_tag (neg_im_out)
	);

	// ---- clamp and output register
	logic [1:0]           t_op;
	logic                 t_dz, t_neg_re;
	logic signed [SW-1:0] t_re, t_im;
	logic [W-1:0]         o_re, o_im;
	logic                 o_sat_re, o_sat_im;
	logic                 done_q;
	cau_res_t             res_q;

	assign {t_op, t_dz, t_neg_re, t_re, t_im} = tag_out;

	function automatic logic [W:0] clamp_v(input logic signed [SW-1:0] v);
		if (v > MAXV) return {1'b1, MAXV[W-1:0]};
		if (v < MINV) return {1'b1, MINV[W-1:0]};
		return {1'b0, v[W-1:0]};
	endfunction

	// {sat, value} from quotient magnitude, overflow and sign
	function automatic logic [W:0] clamp_q(input logic [W-1:0] q, input logic ovf,
			input logic neg);
		if (neg) begin
			if (ovf || q > HALF) return {1'b1, MINV[W-1:0]};
			return {1'b0, -q};
		end
		if (ovf || q[W-1]) return {1'b1, MAXV[W-1:0]};
		return {1'b0, q};
	endfunction

	always_comb begin
		if (t_op == OP_DIV) begin
			if (t_dz) begin
				{o_sat_re, o_re} = '0;
				{o_sat_im, o_im} = '0;
			end else begin
				{o_sat_re, o_re} = clamp_q(dv_q_re, dv_ovf_re, t_neg_re);
				{o_sat_im, o_im} = clamp_q(dv_q_im, dv_ovf_im, neg_im_out);
			end
		end else begin
			{o_sat_re, o_re} = clamp_v(t_re);
			{o_sat_im, o_im} = clamp_v(t_im);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q.res_re    <= to_field(o_re);
		res_q.res_im    <= to_field(o_im);
		res_q.div_zero  <= (t_op == OP_DIV) && t_dz;
		res_q.saturated <= o_sat_re | o_sat_im;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/cau_checker.sv]
// ----------------------------------------------------------------------------
// cau_port_checks
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_port_checks import cau_pkg::*; #(
	parameter int LAT = 38
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input cau_res_t res
);

	// every request gives a result after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after request");

	// no result appears without a request
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without request");

	// zero divisor gives a clean zero result
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.div_zero |-> res.res_re == '0 && res.res_im == '0 && !res.saturated)
		else $error("div_zero result not zero");

	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

endmodule

bind complex_arith_unit cau_port_checks #(.LAT(LATENCY)) u_cau_port_checks (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

[test/cau_checker.sv]
// ----------------------------------------------------------------------------
// cau_checker
// Watches the request and result channels of the complex arithmetic unit,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  cau_req_t req,
	input  logic     done,
	input  cau_res_t res,
	output int       fail_count,
	output int       pending
);

	cau_res_t expected_q[$];

	// clamp a wide value to the signed output range
	function automatic logic signed [FIELD_W-1:0] clamp_part(
		input logic signed [127:0] v, inout logic sat);
		logic signed [127:0] hi_lim;
		logic signed [127:0] lo_lim;
		hi_lim = (128'sd1 <<< (DATA_WIDTH-1)) - 1;
		lo_lim = -(128'sd1 <<< (DATA_WIDTH-1));
		if (v > hi_lim) begin
			sat = 1'b1;
			v = hi_lim;
		end else if (v < lo_lim) begin
			sat = 1'b1;
			v = lo_lim;
		end
		return v[FIELD_W-1:0];
	endfunction

	function automatic cau_res_t complex_result(input cau_req_t r);
		logic signed [127:0] ar, ai, br, bi, re, im, den, nr, ni;
		logic sat;
		cau_res_t o;
		ar = $signed(r.a_re);
		ai = $signed(r.a_im);
		br = $signed(r.b_re);
		bi = $signed(r.b_im);
		sat = 1'b0;
		o.div_zero = 1'b0;
		case (r.op)
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = (ar * br - ai * bi) >>> FRAC_BITS;
				im = (ai * br + ar * bi) >>> FRAC_BITS;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					o.div_zero = 1'b1;
					re = 0;
					im = 0;
				end else begin
					nr = (ar * br + ai * bi) <<< FRAC_BITS;
					ni = (ai * br - ar * bi) <<< FRAC_BITS;
					// SV signed division truncates toward zero
					re = nr / den;
					im = ni / den;
				end
			end
		endcase
		o.res_re = clamp_part(re, sat);
		o.res_im = clamp_part(im, sat);
		o.saturated = sat;
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		cau_res_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected: got %h", $time, res);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want !== res) begin
						$display("%0t: expected re=%h im=%h dz=%b sat=%b, actual re=%h im=%h dz=%b sat=%b",
							$time, want.res_re, want.res_im, want.div_zero, want.saturated,
							res.res_re, res.res_im, res.div_zero, res.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(complex_result(req));
		end
	end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into complex_arith_unit and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
	import cau_pkg::*;

	localparam int LATENCY = 38;
	localparam int N_RANDOM = 1900;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	cau_req_t req;
	cau_res_t res;
	int       fail_count;
	int       pending;
	int       idle_pct;

	complex_arith_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .res(res)
	);

	cau_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// edge-biased operand: extremes, small values, or anything
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
			4, 5: return $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
			default: return $urandom;
		endcase
	endfunction

	// one request; holds start until accepted, with random idle cycles before
	task automatic send(input logic [1:0] op, input logic [31:0] ar, input logic [31:0] ai,
		input logic [31:0] br, input logic [31:0] bi);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		int k;
		logic [1:0] op;
		logic [31:0] br, bi;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = 36;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each op at the extremes, divide by zero, overflow cases
		for (int o = 0; o < 4; o++) begin
			send(o[1:0], 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
			send(o[1:0], 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_ffff);
			send(o[1:0], 32'h0003_8000, 32'hfffe_0000, 32'h0000_0001, 32'h0);
			send(o[1:0], 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
		end
		send(OP_DIV, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0);
		send(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
		send(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0000_0001);
		send(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(OP_SUB, 32'h8000_0000, 32'h0, 32'h0000_0001, 32'h0);

		// pause until the pipe has drained
		start <= 1'b0;
		while (pending != 0) @(posedge clk);

		for (k = 0; k < N_RANDOM; k++) begin
			// a long stretch with no idle cycles in the middle
			idle_pct = (k >= 700 && k < 1000) ? 0 : 36;
			op = 2'($urandom_range(0, 3));
			br = pick_operand();
			bi = pick_operand();
			if (op == OP_DIV && $urandom_range(0, 19) == 0) begin
				br = '0;
				bi = '0;
			end
			send(op, pick_operand(), pick_operand(), br, bi);
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arith_unit.sv
rtl/cau_checker.sv
test/cau_checker.sv
test/testbench.sv
